// File: rtl/ubxfd_pkg.sv
package ubxfd_pkg;

    localparam int unsigned BYTE_W   = 8;
    localparam int unsigned LEN_W    = 16;
    localparam int unsigned CNT_W    = 17;
    localparam int unsigned STATUS_W = 3;
    localparam int unsigned CFG_IDX_W = 2;
    localparam int unsigned CFG_DATA_W = 17;

    localparam logic [CFG_IDX_W-1:0] CFG_SYNC_FIRST  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SYNC_SECOND = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_FRAME   = 2'd2;

    localparam logic [BYTE_W-1:0] RST_SYNC_FIRST  = 8'd181;
    localparam logic [BYTE_W-1:0] RST_SYNC_SECOND = 8'd98;
    localparam logic [CNT_W-1:0]  RST_MAX_FRAME   = 17'd8192;

    localparam logic [STATUS_W-1:0] ST_GARBAGE  = 3'd0;
    localparam logic [STATUS_W-1:0] ST_INSIDE   = 3'd1;
    localparam logic [STATUS_W-1:0] ST_GOOD     = 3'd2;
    localparam logic [STATUS_W-1:0] ST_CK_BAD   = 3'd3;
    localparam logic [STATUS_W-1:0] ST_TOO_LONG = 3'd4;

    localparam logic [2:0] PH_HUNT    = 3'd0;
    localparam logic [2:0] PH_SYNC2   = 3'd1;
    localparam logic [2:0] PH_HEAD    = 3'd2;
    localparam logic [2:0] PH_PAYLOAD = 3'd3;
    localparam logic [2:0] PH_CKA     = 3'd4;
    localparam logic [2:0] PH_CKB     = 3'd5;

    localparam logic [CNT_W-1:0] FRAME_OVERHEAD = 17'd8;
    localparam logic [CNT_W-1:0] HEAD_BYTES     = 17'd6;
    localparam logic [CNT_W-1:0] POS_LEN_LO     = 17'd4;
    localparam logic [CNT_W-1:0] POS_LEN_HI     = 17'd5;

endpackage

// File: rtl/ubx_frame_detector_unit.sv
// Byte-serial UBX frame detector. Each accepted byte produces exactly one
// result transaction carrying the byte, a status (garbage, inside frame,
// frame good, checksum bad, length too large), its position in the frame and,
// on the last byte of a good frame, the total frame length. The block takes
// one byte per clock: the frame state and Fletcher sums update in the cycle a
// byte is accepted and the result lands in a single output register, so a
// new byte is accepted whenever that register is empty or being drained in
// the same cycle. The result appears in the cycle after its byte is accepted.
// Configuration writes (sync bytes, maximum frame length) take effect on the next byte.
module ubx_frame_detector_unit (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_wr_en,
    input  logic [ubxfd_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [ubxfd_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    input  logic                                i_in_valid,
    output logic                                o_in_ready,
    input  logic [ubxfd_pkg::BYTE_W-1:0]        i_data_byte,
    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output logic [ubxfd_pkg::BYTE_W-1:0]        o_byte_out,
    output logic [ubxfd_pkg::STATUS_W-1:0]      o_status,
    output logic [ubxfd_pkg::CNT_W-1:0]         o_position,
    output logic [ubxfd_pkg::CNT_W-1:0]         o_frame_length
);
    import ubxfd_pkg::*;

    logic [BYTE_W-1:0]   r_sync_first;
    logic [BYTE_W-1:0]   r_sync_second;
    logic [CNT_W-1:0]    r_max_frame;

    logic [2:0]          r_phase, n_phase;
    logic [LEN_W-1:0]    r_len, n_len;
    logic [CNT_W-1:0]    r_cnt, n_cnt;
    logic [BYTE_W-1:0]   r_sum_a, n_sum_a;
    logic [BYTE_W-1:0]   r_sum_b, n_sum_b;
    logic [BYTE_W-1:0]   r_ck_a, n_ck_a;

    logic                r_out_valid;
    logic [BYTE_W-1:0]   r_byte;
    logic [STATUS_W-1:0] r_status, n_status;
    logic [CNT_W-1:0]    r_pos, n_pos;
    logic [CNT_W-1:0]    r_flen, n_flen;

    logic                w_accept;
    logic [BYTE_W-1:0]   w_acc_a;
    logic [BYTE_W-1:0]   w_acc_b;
    logic [CNT_W-1:0]    w_cnt_inc;
    logic [LEN_W-1:0]    w_len_full;
    logic [CNT_W-1:0]    w_total;

    assign o_in_ready = !r_out_valid || i_out_ready;
    assign w_accept   = i_in_valid && o_in_ready;

    assign w_acc_a    = r_sum_a + i_data_byte;
    assign w_acc_b    = r_sum_b + w_acc_a;
    assign w_cnt_inc  = r_cnt + 17'd1;
    assign w_len_full = {i_data_byte, r_len[7:0]};
    assign w_total    = {1'b0, w_len_full} + FRAME_OVERHEAD;

    always_comb begin
        n_phase  = r_phase;
        n_len    = r_len;
        n_cnt    = r_cnt;
        n_sum_a  = r_sum_a;
        n_sum_b  = r_sum_b;
        n_ck_a   = r_ck_a;
        n_status = ST_GARBAGE;
        n_pos    = '0;
        n_flen   = '0;
        unique case (r_phase)
            PH_SYNC2: begin
                if (i_data_byte == r_sync_second) begin
                    n_status = ST_INSIDE;
                    n_pos    = 17'd1;
                    n_cnt    = 17'd2;
                    n_sum_a  = '0;
                    n_sum_b  = '0;
                    n_len    = '0;
                    n_phase  = PH_HEAD;
                end else if (i_data_byte == r_sync_first) begin
                    n_status = ST_INSIDE;
                    n_cnt    = 17'd1;
                end else begin
                    n_phase = PH_HUNT;
                    n_cnt   = '0;
                end
            end
            PH_HEAD: begin
                n_pos    = r_cnt;
                n_sum_a  = w_acc_a;
                n_sum_b  = w_acc_b;
                n_status = ST_INSIDE;
                n_cnt    = w_cnt_inc;
                if (r_cnt == POS_LEN_LO) begin
                    n_len = {8'd0, i_data_byte};
                end
                if (r_cnt >= POS_LEN_HI) begin
                    n_len = w_len_full;
                    if (w_total > r_max_frame) begin
                        n_status = ST_TOO_LONG;
                        n_phase  = PH_HUNT;
                        n_cnt    = '0;
                    end else if (w_len_full != '0) begin
                        n_phase = PH_PAYLOAD;
                    end else begin
                        n_phase = PH_CKA;
                    end
                end
            end
            PH_PAYLOAD: begin
                n_pos    = r_cnt;
                n_sum_a  = w_acc_a;
                n_sum_b  = w_acc_b;
                n_status = ST_INSIDE;
                n_cnt    = w_cnt_inc;
                if (w_cnt_inc >= HEAD_BYTES + {1'b0, r_len}) begin
                    n_phase = PH_CKA;
                end
            end
            PH_CKA: begin
                n_pos    = r_cnt;
                n_ck_a   = i_data_byte;
                n_status = ST_INSIDE;
                n_cnt    = w_cnt_inc;
                n_phase  = PH_CKB;
            end
            PH_CKB: begin
                n_pos = r_cnt;
                if (r_ck_a == r_sum_a && i_data_byte == r_sum_b) begin
                    n_status = ST_GOOD;
                    n_flen   = {1'b0, r_len} + FRAME_OVERHEAD;
                end else begin
                    n_status = ST_CK_BAD;
                end
                n_phase = PH_HUNT;
                n_cnt   = '0;
            end
            default: begin
                if (i_data_byte == r_sync_first) begin
                    n_status = ST_INSIDE;
                    n_cnt    = 17'd1;
                    n_phase  = PH_SYNC2;
                end else begin
                    n_phase = PH_HUNT;
                    n_cnt   = '0;
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sync_first  <= RST_SYNC_FIRST;
            r_sync_second <= RST_SYNC_SECOND;
            r_max_frame   <= RST_MAX_FRAME;
        end else if (i_cfg_wr_en) begin
            unique case (i_cfg_index)
                CFG_SYNC_FIRST:  r_sync_first  <= i_cfg_data[BYTE_W-1:0];
                CFG_SYNC_SECOND: r_sync_second <= i_cfg_data[BYTE_W-1:0];
                CFG_MAX_FRAME:   r_max_frame   <= i_cfg_data[CNT_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_HUNT;
            r_len       <= '0;
            r_cnt       <= '0;
            r_sum_a     <= '0;
            r_sum_b     <= '0;
            r_ck_a      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_accept) begin
                r_phase <= n_phase;
                r_len   <= n_len;
                r_cnt   <= n_cnt;
                r_sum_a <= n_sum_a;
                r_sum_b <= n_sum_b;
                r_ck_a  <= n_ck_a;
            end
            if (w_accept) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_byte   <= i_data_byte;
            r_status <= n_status;
            r_pos    <= n_pos;
            r_flen   <= n_flen;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_byte_out     = r_byte;
    assign o_status       = r_status;
    assign o_position     = r_pos;
    assign o_frame_length = r_flen;

`ifndef NO_ASSERTIONS
    a_flen_only_good: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_status != ST_GOOD |-> r_flen == '0)
        else $error("frame length reported on a non-good byte");

    a_good_len_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_status == ST_GOOD |-> r_flen == r_pos + 17'd1)
        else $error("good frame length disagrees with last byte position");

    a_garbage_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_status == ST_GARBAGE |-> r_pos == '0)
        else $error("garbage byte with nonzero position");

    a_hunt_cnt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_phase == PH_HUNT |-> r_cnt == '0)
        else $error("byte counter not cleared while hunting");

    a_head_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_phase == PH_HEAD |-> r_cnt >= 17'd2 && r_cnt <= POS_LEN_HI)
        else $error("header byte counter out of range");
`endif

endmodule

// File: tb/tb_ubx_frame_detector_unit.sv
`timescale 1ns / 1ps

module tb_ubx_frame_detector_unit;
    import ubxfd_pkg::*;

    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;
    localparam int NUM_SETTINGS   = 8;
    localparam int SETTING_BYTES  = 240;
    localparam int WATCHDOG_LIMIT = 1000;
    localparam int DIR_N          = 27;

    typedef struct packed {
        logic [BYTE_W-1:0]   data;
        logic [STATUS_W-1:0] status;
        logic [CNT_W-1:0]    position;
        logic [CNT_W-1:0]    frame_len;
    } t_det_result;

    typedef struct packed {
        logic [BYTE_W-1:0]   data;
        logic                typed;
        logic [STATUS_W-1:0] status;
        logic [CNT_W-1:0]    position;
        logic [CNT_W-1:0]    frame_len;
    } t_dir_row;

    // typed = 0: checksum bytes, checked against the predictor
    localparam t_dir_row DIR_ROWS [DIR_N] = '{
        '{8'hB5, 1'b1, ST_INSIDE,   17'd0, 17'd0},
        '{8'h00, 1'b1, ST_GARBAGE,  17'd0, 17'd0},
        '{8'hB5, 1'b1, ST_INSIDE,   17'd0, 17'd0},
        '{8'hB5, 1'b1, ST_INSIDE,   17'd0, 17'd0},
        '{8'h62, 1'b1, ST_INSIDE,   17'd1, 17'd0},
        '{8'h01, 1'b1, ST_INSIDE,   17'd2, 17'd0},
        '{8'h07, 1'b1, ST_INSIDE,   17'd3, 17'd0},
        '{8'h02, 1'b1, ST_INSIDE,   17'd4, 17'd0},
        '{8'h00, 1'b1, ST_INSIDE,   17'd5, 17'd0},
        '{8'hAA, 1'b1, ST_INSIDE,   17'd6, 17'd0},
        '{8'h55, 1'b1, ST_INSIDE,   17'd7, 17'd0},
        '{8'h09, 1'b0, ST_INSIDE,   17'd0, 17'd0},
        '{8'hDA, 1'b0, ST_INSIDE,   17'd0, 17'd0},
        '{8'hB5, 1'b1, ST_INSIDE,   17'd0, 17'd0},
        '{8'h62, 1'b1, ST_INSIDE,   17'd1, 17'd0},
        '{8'h05, 1'b1, ST_INSIDE,   17'd2, 17'd0},
        '{8'h01, 1'b1, ST_INSIDE,   17'd3, 17'd0},
        '{8'h00, 1'b1, ST_INSIDE,   17'd4, 17'd0},
        '{8'h00, 1'b1, ST_INSIDE,   17'd5, 17'd0},
        '{8'h06, 1'b1, ST_INSIDE,   17'd6, 17'd0},
        '{8'h18, 1'b1, ST_CK_BAD,   17'd7, 17'd0},
        '{8'hB5, 1'b1, ST_INSIDE,   17'd0, 17'd0},
        '{8'h62, 1'b1, ST_INSIDE,   17'd1, 17'd0},
        '{8'h0A, 1'b1, ST_INSIDE,   17'd2, 17'd0},
        '{8'h0B, 1'b1, ST_INSIDE,   17'd3, 17'd0},
        '{8'hFF, 1'b1, ST_INSIDE,   17'd4, 17'd0},
        '{8'hFF, 1'b1, ST_TOO_LONG, 17'd5, 17'd0}
    };

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_cfg_wr_en;
    logic [CFG_IDX_W-1:0]  i_cfg_index;
    logic [CFG_DATA_W-1:0] i_cfg_data;
    logic                  i_in_valid;
    logic                  o_in_ready;
    logic [BYTE_W-1:0]     i_data_byte;
    logic                  o_out_valid;
    logic                  i_out_ready;
    logic [BYTE_W-1:0]     o_byte_out;
    logic [STATUS_W-1:0]   o_status;
    logic [CNT_W-1:0]      o_position;
    logic [CNT_W-1:0]      o_frame_length;

    ubx_frame_detector_unit dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_wr_en    (i_cfg_wr_en),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_data_byte    (i_data_byte),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_byte_out     (o_byte_out),
        .o_status       (o_status),
        .o_position     (o_position),
        .o_frame_length (o_frame_length)
    );

    // register mirror
    logic [BYTE_W-1:0] cfg_sync_first  = RST_SYNC_FIRST;
    logic [BYTE_W-1:0] cfg_sync_second = RST_SYNC_SECOND;
    logic [CNT_W-1:0]  cfg_max_frame   = RST_MAX_FRAME;

    // detector state mirror
    logic [2:0]        det_phase = PH_HUNT;
    logic [LEN_W-1:0]  det_len   = '0;
    logic [CNT_W-1:0]  det_cnt   = '0;
    logic [BYTE_W-1:0] det_a     = '0;
    logic [BYTE_W-1:0] det_b     = '0;
    logic [BYTE_W-1:0] det_ck_a  = '0;

    t_det_result frame_results_q [$];
    t_det_result mon_want;

    bit steady;
    int mismatches;
    int bytes_sent;
    int stall_left;
    int stall_cycles;
    int n_good, n_ck_bad, n_too_long, n_garbage;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic void fletcher_add(input logic [BYTE_W-1:0] b);
        det_a = det_a + b;
        det_b = det_b + det_a;
    endfunction

    function automatic t_det_result detect_step(input logic [BYTE_W-1:0] b);
        t_det_result r;
        r = '0;
        r.data = b;
        case (det_phase)
            PH_SYNC2: begin
                if (b == cfg_sync_second) begin
                    r.status   = ST_INSIDE;
                    r.position = 17'd1;
                    det_cnt    = 17'd2;
                    det_a      = '0;
                    det_b      = '0;
                    det_len    = '0;
                    det_phase  = PH_HEAD;
                end else if (b == cfg_sync_first) begin
                    r.status = ST_INSIDE;
                    det_cnt  = 17'd1;
                end else begin
                    det_phase = PH_HUNT;
                    det_cnt   = '0;
                end
            end
            PH_HEAD: begin
                r.position = det_cnt;
                r.status   = ST_INSIDE;
                fletcher_add(b);
                if (det_cnt == POS_LEN_LO)
                    det_len = {8'h00, b};
                det_cnt = det_cnt + 17'd1;
                if (r.position >= POS_LEN_HI) begin
                    det_len = {b, det_len[7:0]};
                    if ({1'b0, det_len} + FRAME_OVERHEAD > cfg_max_frame) begin
                        r.status  = ST_TOO_LONG;
                        det_phase = PH_HUNT;
                        det_cnt   = '0;
                    end else begin
                        det_phase = (det_len != '0) ? PH_PAYLOAD : PH_CKA;
                    end
                end
            end
            PH_PAYLOAD: begin
                r.position = det_cnt;
                r.status   = ST_INSIDE;
                fletcher_add(b);
                det_cnt = det_cnt + 17'd1;
                if (det_cnt >= HEAD_BYTES + {1'b0, det_len})
                    det_phase = PH_CKA;
            end
            PH_CKA: begin
                r.position = det_cnt;
                r.status   = ST_INSIDE;
                det_ck_a   = b;
                det_cnt    = det_cnt + 17'd1;
                det_phase  = PH_CKB;
            end
            PH_CKB: begin
                r.position = det_cnt;
                if (det_ck_a == det_a && b == det_b) begin
                    r.status    = ST_GOOD;
                    r.frame_len = {1'b0, det_len} + FRAME_OVERHEAD;
                end else begin
                    r.status = ST_CK_BAD;
                end
                det_phase = PH_HUNT;
                det_cnt   = '0;
            end
            default: begin
                det_phase = PH_HUNT;
                if (b == cfg_sync_first) begin
                    r.status  = ST_INSIDE;
                    det_cnt   = 17'd1;
                    det_phase = PH_SYNC2;
                end else begin
                    det_cnt = '0;
                end
            end
        endcase
        return r;
    endfunction

    function automatic int pick_gap();
        int r;
        if (steady)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 93)
            return $urandom_range(1, 3);
        return $urandom_range(6, 40);
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("tb: mismatch on %s: got %0d, want %0d (byte %0d)",
                 what, got, want, bytes_sent);
        mismatches++;
    endtask

    task automatic send_byte(input logic [BYTE_W-1:0] b, input logic typed,
                             input t_det_result want);
        int gap;
        t_det_result pred;
        gap = pick_gap();
        if (gap != 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid  <= 1'b1;
        i_data_byte <= b;
        do @(posedge i_clk); while (!o_in_ready);
        pred = detect_step(b);
        frame_results_q.push_back(typed ? want : pred);
        bytes_sent++;
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] val);
        i_cfg_wr_en <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b0;
        @(posedge i_clk);
        case (idx)
            CFG_SYNC_FIRST:  cfg_sync_first  = val[BYTE_W-1:0];
            CFG_SYNC_SECOND: cfg_sync_second = val[BYTE_W-1:0];
            CFG_MAX_FRAME:   cfg_max_frame   = val[CNT_W-1:0];
            default: ;
        endcase
    endtask

    task automatic drain();
        i_in_valid <= 1'b0;
        while (frame_results_q.size() != 0) @(posedge i_clk);
        repeat (2) @(posedge i_clk);
    endtask

    task automatic send_frame();
        logic [BYTE_W-1:0] fb [$];
        logic [BYTE_W-1:0] body [$];
        logic [BYTE_W-1:0] ca, cb;
        int kind, plen, lo, hi, cut;
        bit oversize;
        kind     = $urandom_range(0, 99);
        oversize = (kind >= 10 && kind < 20 && cfg_max_frame <= 17'd65542);
        if (kind < 10) begin
            repeat ($urandom_range(1, 8)) fb.push_back(BYTE_W'($urandom_range(0, 255)));
        end else begin
            if (oversize) begin
                lo   = (cfg_max_frame < FRAME_OVERHEAD) ? 0 : int'(cfg_max_frame) - 7;
                hi   = (lo + 300 > 65535) ? 65535 : lo + 300;
                plen = $urandom_range(hi, lo);
            end else if (cfg_max_frame >= FRAME_OVERHEAD && cfg_max_frame < 17'd100 &&
                         $urandom_range(0, 2) == 0) begin
                plen = int'(cfg_max_frame) - 8 - int'($urandom_range(0, 1));
                if (plen < 0)
                    plen = 0;
            end else if ($urandom_range(0, 9) == 0) begin
                plen = $urandom_range(21, 90);
            end else begin
                plen = $urandom_range(0, 20);
            end
            fb.push_back(cfg_sync_first);
            if (cfg_sync_first != cfg_sync_second && $urandom_range(0, 9) == 0)
                fb.push_back(cfg_sync_first);
            fb.push_back(cfg_sync_second);
            body.push_back(BYTE_W'($urandom_range(0, 255)));
            body.push_back(BYTE_W'($urandom_range(0, 255)));
            body.push_back(plen[7:0]);
            body.push_back(plen[15:8]);
            if (!oversize)
                repeat (plen) body.push_back(BYTE_W'($urandom_range(0, 255)));
            ca = '0;
            cb = '0;
            foreach (body[i]) begin
                ca = ca + body[i];
                cb = cb + ca;
                fb.push_back(body[i]);
            end
            if (!oversize) begin
                if (kind >= 20 && kind < 30) begin
                    if ($urandom_range(0, 1) == 0)
                        ca = ca ^ (8'h01 << $urandom_range(0, 7));
                    else
                        cb = cb ^ (8'h01 << $urandom_range(0, 7));
                end
                fb.push_back(ca);
                fb.push_back(cb);
                if (kind >= 30 && kind < 38) begin
                    cut = $urandom_range(1, fb.size() - 2);
                    fb  = fb[0:cut];
                end
            end
        end
        foreach (fb[i]) send_byte(fb[i], 1'b0, '0);
    endtask

    initial begin
        i_out_ready <= 1'b0;
        stall_left = 0;
        forever begin
            @(posedge i_clk);
            if (stall_left != 0) begin
                i_out_ready <= 1'b0;
                stall_left--;
            end else begin
                i_out_ready <= 1'b1;
                stall_left = pick_gap();
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (frame_results_q.size() == 0) begin
                report_mismatch("unexpected transaction", 32'(o_byte_out), 32'd0);
            end else begin
                mon_want = frame_results_q.pop_front();
                if (o_byte_out !== mon_want.data)
                    report_mismatch("byte_out", 32'(o_byte_out), 32'(mon_want.data));
                if (o_status !== mon_want.status)
                    report_mismatch("status", 32'(o_status), 32'(mon_want.status));
                if (o_position !== mon_want.position)
                    report_mismatch("position", 32'(o_position),
                                    32'(mon_want.position));
                if (o_frame_length !== mon_want.frame_len)
                    report_mismatch("frame_length", 32'(o_frame_length),
                                    32'(mon_want.frame_len));
            end
            case (o_status)
                ST_GOOD:     n_good++;
                ST_CK_BAD:   n_ck_bad++;
                ST_TOO_LONG: n_too_long++;
                ST_GARBAGE:  n_garbage++;
                default: ;
            endcase
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)) begin
            stall_cycles <= 0;
        end else begin
            stall_cycles <= stall_cycles + 1;
            if (stall_cycles >= WATCHDOG_LIMIT) begin
                $display("tb: failure");
                $finish;
            end
        end
    end

    initial begin
        int p, start;
        logic [BYTE_W-1:0] s1, s2;
        logic [8:0] junk;
        logic [CNT_W-1:0] mx;
        t_det_result typed_res;
        steady = 1'b0;
        i_rst_n     <= 1'b0;
        i_cfg_wr_en <= 1'b0;
        i_cfg_index <= '0;
        i_cfg_data  <= '0;
        i_in_valid  <= 1'b0;
        i_data_byte <= '0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        for (int i = 0; i < DIR_N; i++) begin
            typed_res.data      = DIR_ROWS[i].data;
            typed_res.status    = DIR_ROWS[i].status;
            typed_res.position  = DIR_ROWS[i].position;
            typed_res.frame_len = DIR_ROWS[i].frame_len;
            send_byte(DIR_ROWS[i].data, DIR_ROWS[i].typed, typed_res);
        end

        for (p = 0; p < NUM_SETTINGS; p++) begin
            drain();
            s1 = BYTE_W'($urandom_range(0, 255));
            s2 = BYTE_W'($urandom_range(0, 255));
            if (p == 2)
                s2 = s1;
            if (p == 3) begin
                s1 = 8'h00;
                s2 = 8'hFF;
            end
            if (p == 5) begin
                s1 = 8'hFF;
                s2 = 8'h00;
            end
            case (p)
                0:       mx = '0;
                1:       mx = 17'd8;
                2:       mx = 17'd65543;
                3:       mx = '1;
                4:       mx = CNT_W'($urandom_range(9, 40));
                5:       mx = 17'd7;
                6:       mx = CNT_W'($urandom_range(41, 300));
                default: mx = RST_MAX_FRAME;
            endcase
            junk = 9'($urandom_range(0, 511));
            write_reg(CFG_SYNC_FIRST, {junk, s1});
            junk = 9'($urandom_range(0, 511));
            write_reg(CFG_SYNC_SECOND, {junk, s2});
            write_reg(CFG_MAX_FRAME, mx);
            if (p % 2 == 1)
                write_reg(CFG_UNUSED, CFG_DATA_W'($urandom_range(0, 131071)));
            steady = (p % 3 == 1);
            start  = bytes_sent;
            while (bytes_sent < start + SETTING_BYTES)
                send_frame();
        end
        drain();
        repeat (4) @(posedge i_clk);

        $display("tb: %0d bytes under %0d register settings, idle and stalled on both sides",
                 bytes_sent, NUM_SETTINGS + 1);
        $display("tb: frames good %0d, checksum bad %0d, too long %0d; garbage bytes %0d",
                 n_good, n_ck_bad, n_too_long, n_garbage);
        if (mismatches == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
